>>> rtl/assert_macros.svh
// assertion helpers for the charge yield block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ICY_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("icy assertion failed");
`define ICY_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("icy forbidden condition");
`else
`define ICY_ASSERT(name, prop)
`define ICY_NEVER(name, cond)
`endif
`endif

>>> rtl/icy_pkg.sv
package icy_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned CfgWidth = 7;
  localparam logic [CfgWidth-1:0] CfgReset = 7'd2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic we;
    logic re;
  } tbl_ctrl_t;

endpackage

>>> rtl/interpolated_charge_yield_core.sv
// piecewise-linear charge yield lookup: load transactions (cmd 0) write one
// energy/yield pair into the table and give no result; query transactions
// (cmd 1) walk the table from entry 0 for the first energy not below the
// query, interpolate the yield against the entry before it, and multiply by
// the deposit to give a truncated electron count, with out_of_range set when
// the energy lies outside the table and the end yield was used. a load writes
// its entry while the block stays idle. a query searches the entries in use
// with a table memory read and a compare per entry, then a shared 32x32
// multiplier, a bit-serial divider and a second multiply on the shared
// multiplier finish the answer. a query at or below the first entry, past
// the last entry in use or on a zero gap skips the division. a busy output
// register holds the query in its last multiply until the waiting result
// is taken.
// the table is not cleared by reset; only written entries may be queried
`include "assert_macros.svh"

module interpolated_charge_yield_core #(
  parameter int unsigned TABLE_DEPTH = icy_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] entry_energy_i,
  input  logic [31:0] entry_yield_i,
  input  logic [31:0] energy_i,
  input  logic [31:0] deposit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] electrons_o,
  output logic        out_of_range_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (NW > icy_pkg::CfgWidth) ? NW : icy_pkg::CfgWidth;
  localparam int unsigned XW = ((AW > 6) ? AW : 6) + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_DIVGO = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_ADJ   = 8'b0100_0000,
    S_MUL2  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]    cfg_q;
  logic [AW-1:0] idx_q;
  logic [31:0]   energy_q, deposit_q;
  logic [31:0]   prev_e_q, prev_y_q;
  logic [31:0]   yl_q, diff_q, rem_q, gap_q, y_q;
  logic          neg_q, flag_q;
  logic [63:0]   mul_q;
  logic          out_valid_q, out_flag_q;
  logic [31:0]   out_el_q;

  // entry count clamp to 2..depth
  logic [CW-1:0] n_ext, n_clamp;
  logic [AW-1:0] last_idx;
  always_comb begin
    n_ext = CW'(cfg_q);
    if (n_ext < CW'(2)) begin
      n_clamp = CW'(2);
    end else if (n_ext > CW'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = n_ext;
    end
    last_idx = AW'(n_clamp - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= icy_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // table memory
  icy_pkg::tbl_ctrl_t tbl_ctrl;
  logic [63:0]        rd_data;
  logic [31:0]        rd_e, rd_y;
  logic               in_acc, idx_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ok     = XW'(entry_index_i) < XW'(TABLE_DEPTH);
  assign tbl_ctrl.we = in_acc && (cmd_i == icy_pkg::CmdLoad) && idx_ok;
  assign tbl_ctrl.re = (state_q == S_RD);

  icy_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_energy_i, entry_yield_i}),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign rd_e = rd_data[63:32];
  assign rd_y = rd_data[31:0];

  // divider for (dy * rem) / gap
  icy_pkg::div_status_t div_st;
  logic [63:0]          quo;

  icy_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVGO),
    .dividend_i (mul_q),
    .divisor_i  (gap_q),
    .status_o   (div_st),
    .quotient_o (quo)
  );

  logic found;
  assign found = rd_e >= energy_q;

  // output slot free for the final product
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // shared multiplier pending flag, set once the second product is in mul_q
  logic mul2_pend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && (cmd_i == icy_pkg::CmdQuery)) state_d = S_RD;
      S_RD:    state_d = S_CMP;
      S_CMP: begin
        if (found) begin
          if (idx_q == '0) begin
            state_d = S_MUL2;
          end else if ((rd_e - prev_e_q) == 32'd0) begin
            state_d = S_MUL2;
          end else begin
            state_d = S_MUL1;
          end
        end else if (idx_q == last_idx) begin
          state_d = S_MUL2;
        end else begin
          state_d = S_RD;
        end
      end
      S_MUL1:  state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   if (div_st.done) state_d = S_ADJ;
      S_ADJ:   state_d = S_MUL2;
      S_MUL2:  if (mul2_pend_q && out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // shared multiplier, registered; the second product waits for the slot
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  assign mul_a  = (state_q == S_MUL1) ? diff_q : y_q;
  assign mul_b  = (state_q == S_MUL1) ? rem_q : deposit_q;
  assign mul_en = (state_q == S_MUL1) || ((state_q == S_MUL2) && !mul2_pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul2_pend_q <= 1'b0;
    end else begin
      mul2_pend_q <= (state_q == S_MUL2) && !(mul2_pend_q && out_free);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // search and interpolation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q     <= '0;
        energy_q  <= energy_i;
        deposit_q <= deposit_i;
      end
      S_CMP: begin
        prev_e_q <= rd_e;
        prev_y_q <= rd_y;
        if (found) begin
          if (idx_q == '0) begin
            y_q    <= rd_y;
            flag_q <= energy_q < rd_e;
          end else begin
            y_q    <= prev_y_q;
            flag_q <= 1'b0;
            yl_q   <= prev_y_q;
            gap_q  <= rd_e - prev_e_q;
            rem_q  <= energy_q - prev_e_q;
            neg_q  <= rd_y < prev_y_q;
            diff_q <= (rd_y < prev_y_q) ? (prev_y_q - rd_y) : (rd_y - prev_y_q);
          end
        end else begin
          // past the end: keep the last yield in use
          y_q    <= rd_y;
          flag_q <= 1'b1;
          idx_q  <= idx_q + AW'(1);
        end
      end
      S_ADJ: begin
        if (!neg_q) begin
          y_q <= (quo > {32'd0, ~yl_q}) ? 32'hFFFF_FFFF : yl_q + quo[31:0];
        end else begin
          y_q <= (quo > {32'd0, yl_q}) ? 32'd0 : yl_q - quo[31:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_MUL2 && mul2_pend_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL2 && mul2_pend_q && out_free) begin
      out_el_q   <= mul_q[63:32];
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign electrons_o    = out_el_q;
  assign out_of_range_o = out_flag_q;

  `ICY_ASSERT(a_div_done_in_div, div_st.done |-> (state_q == S_DIV))
  `ICY_ASSERT(a_cmp_after_read, (state_q == S_CMP) |-> ($past(state_q) == S_RD))
  `ICY_ASSERT(a_query_starts_search, (in_acc && (cmd_i == icy_pkg::CmdQuery)) |=> (state_q == S_RD))
  `ICY_NEVER(a_div_busy_outside, div_st.busy && (state_q != S_DIV))

endmodule

>>> rtl/icy_table.sv
module icy_table #(
  parameter int unsigned TABLE_DEPTH = icy_pkg::TableDepthDefault,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  icy_pkg::tbl_ctrl_t ctrl_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [63:0]       wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [63:0]       rdata_o
);

  // energy in the upper half, yield in the lower half
  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/icy_div.sv
module icy_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          dividend_i,
  input  logic [31:0]          divisor_i,
  output icy_pkg::div_status_t status_o,
  output logic [63:0]          quotient_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic        ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[63]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
    quo_d = {quo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule
